// ===== hdl/pse_pkg.sv =====
// Shared widths, constants and mark codes for the prime sieve engine.
`timescale 1ns / 1ps
package pse_pkg;

    localparam int PSE_SIZE    = 65536;
    localparam int PSE_NUM_W   = 16;
    localparam int PSE_LIMIT_W = 17;
    localparam int PSE_IDX_W   = 18;
    localparam int PSE_MARK_W  = 2;

    localparam logic [PSE_LIMIT_W-1:0] PSE_LIMIT_RESET = 17'h10000;

    typedef enum logic [PSE_MARK_W-1:0] {
        MARK_UNCLEAR   = 2'd0,
        MARK_PRIME     = 2'd1,
        MARK_COMPOSITE = 2'd2
    } mark_t;

endpackage

// ===== hdl/pse_if.sv =====
// Valid/ready channel interfaces for candidate and result items.
`timescale 1ns / 1ps
interface pse_in_if;
    logic                          valid;
    logic                          ready;
    logic                          clear;
    logic [pse_pkg::PSE_NUM_W-1:0] number;

    modport source (output valid, output clear, output number, input ready);
    modport sink (input valid, input clear, input number, output ready);
endinterface

interface pse_out_if;
    logic                          valid;
    logic                          ready;
    logic [pse_pkg::PSE_NUM_W-1:0] number_out;
    logic                          is_prime;
    logic                          out_of_range;

    modport source (output valid, output number_out, output is_prime, output out_of_range,
                    input ready);
    modport sink (input valid, input number_out, input is_prime, input out_of_range,
                  output ready);
endinterface

// ===== hdl/prime_sieve_engine.sv =====
// Top level of the prime sieve engine: sequencer, mark memory and result register.
// Flow: a rejected candidate goes straight to the result state; a stored mark is looked up
//   first; a new prime also strikes its multiples below the limit; a clear sweeps the memory.
// Throughput: the next item is taken in the cycle after a result loads; a held result stalls.
// Reset: limit returns to 65536 and a clearing pass sweeps all SIZE entries of the
//   mark memory; no item is accepted during it, configuration writes are taken.
`timescale 1ns / 1ps
module prime_sieve_engine #(
    parameter int SIZE = pse_pkg::PSE_SIZE
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pse_pkg::PSE_LIMIT_W-1:0]  cfg_wdata,
    pse_in_if.sink                           request,
    pse_out_if.source                        response
);
    import pse_pkg::*;

    localparam int AW = $clog2(SIZE);
    localparam logic [PSE_IDX_W-1:0] SIZE_CAP =
        (SIZE > 131072) ? 18'd131072 : PSE_IDX_W'(SIZE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SIZE - 1);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_LOOK  = 6'b000100,
        ST_MARK  = 6'b001000,
        ST_DONE  = 6'b010000,
        ST_SPARE = 6'b100000
    } state_t;

    state_t                  state_reg, state_next;
    logic [PSE_LIMIT_W-1:0]  limit_reg;
    logic [AW-1:0]           clr_cnt_reg, clr_cnt_next;
    logic [PSE_IDX_W-1:0]    idx_reg, idx_next;
    logic [PSE_NUM_W-1:0]    num_reg, num_next;
    logic                    clear_item_reg, clear_item_next;
    logic                    prime_reg, prime_next;
    logic                    oor_reg, oor_next;
    logic                    out_valid_reg;
    logic [PSE_NUM_W-1:0]    out_num_reg;
    logic                    out_prime_reg;
    logic                    out_oor_reg;

    logic [PSE_IDX_W-1:0]    eff_lim;
    logic                    accept;
    logic                    load;
    logic                    wr_en;
    logic [AW-1:0]           wr_addr;
    mark_t                   wr_data;
    logic                    rd_en;
    logic [AW-1:0]           rd_addr;
    logic [PSE_MARK_W-1:0]   rd_data;
    mark_t                   rd_mark;

    assign eff_lim = ({1'b0, limit_reg} > SIZE_CAP) ? SIZE_CAP : {1'b0, limit_reg};
    assign request.ready = (state_reg == ST_IDLE);
    assign accept = request.valid && request.ready;
    assign load = (state_reg == ST_DONE) && (!out_valid_reg || response.ready);
    assign rd_mark = mark_t'(rd_data);

    assign response.valid        = out_valid_reg;
    assign response.number_out   = out_num_reg;
    assign response.is_prime     = out_prime_reg;
    assign response.out_of_range = out_oor_reg;

    pse_mark_ram #(
        .DEPTH (SIZE)
    ) u_mark_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        idx_next        = idx_reg;
        num_next        = num_reg;
        clear_item_next = clear_item_reg;
        prime_next      = prime_reg;
        oor_next        = oor_reg;
        wr_en           = 1'b0;
        wr_addr         = clr_cnt_reg;
        wr_data         = MARK_UNCLEAR;
        rd_en           = 1'b0;
        rd_addr         = AW'(request.number);
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en = 1'b1;
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    clr_cnt_next = '0;
                    state_next   = clear_item_reg ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    num_next        = request.number;
                    clear_item_next = request.clear;
                    prime_next      = 1'b0;
                    oor_next        = 1'b0;
                    if (request.clear)
                    begin
                        state_next = ST_CLEAR;
                    end
                    else if ({2'b00, request.number} >= eff_lim)
                    begin
                        oor_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else if (request.number < 16'd2)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_en      = 1'b1;
                        state_next = ST_LOOK;
                    end
                end
            end
            ST_LOOK:
            begin
                case (rd_mark)
                    MARK_UNCLEAR:
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = AW'(num_reg);
                        wr_data    = MARK_PRIME;
                        prime_next = 1'b1;
                        idx_next   = {1'b0, num_reg, 1'b0};
                        state_next = ST_MARK;
                    end
                    MARK_PRIME:
                    begin
                        prime_next = 1'b1;
                        state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_MARK:
            begin
                if (idx_reg < eff_lim)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = AW'(idx_reg);
                    wr_data  = MARK_COMPOSITE;
                    idx_next = idx_reg + {2'b00, num_reg};
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            limit_reg      <= PSE_LIMIT_RESET;
            clr_cnt_reg    <= '0;
            clear_item_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clear_item_reg <= clear_item_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (response.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        num_reg   <= num_next;
        prime_reg <= prime_next;
        oor_reg   <= oor_next;
        if (load)
        begin
            out_num_reg   <= num_reg;
            out_prime_reg <= prime_reg;
            out_oor_reg   <= oor_reg;
        end
    end

    a_oor_direct: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !request.clear && ({2'b00, request.number} >= eff_lim)
        |=> (state_reg == ST_DONE) && oor_reg)
        else $error("out-of-range candidate did not go straight to a result");

    a_result_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        response.valid |-> !(response.is_prime && response.out_of_range))
        else $error("result flagged both prime and out of range");

    a_strike_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK) && wr_en
        |-> (idx_reg < eff_lim) && (idx_reg >= {1'b0, num_reg, 1'b0}))
        else $error("strike write outside the marked range");

    a_look_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |=> (state_reg == ST_LOOK))
        else $error("mark read not followed by lookup");

    a_clear_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> wr_en && (wr_data == MARK_UNCLEAR) && !request.ready)
        else $error("clearing pass stalled or wrote a mark");

endmodule

// ===== hdl/pse_mark_ram.sv =====
// Single-port-write, registered-read mark memory.
`timescale 1ns / 1ps
module pse_mark_ram #(
    parameter int DEPTH = pse_pkg::PSE_SIZE
) (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [$clog2(DEPTH)-1:0]        wr_addr,
    input  logic [pse_pkg::PSE_MARK_W-1:0]  wr_data,
    input  logic                            rd_en,
    input  logic [$clog2(DEPTH)-1:0]        rd_addr,
    output logic [pse_pkg::PSE_MARK_W-1:0]  rd_data
);
    import pse_pkg::*;

    logic [PSE_MARK_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for prime_sieve_engine: sieve predictor, random valid/ready traffic.
`timescale 1ns / 1ps
module testbench;
    import pse_pkg::*;

    localparam int STALL_LIMIT = 300000;
    localparam int IDLE_PCT    = 24;

    typedef struct packed {
        logic                 clear;
        logic [PSE_NUM_W-1:0] number;
    } candidate_t;

    typedef struct packed {
        logic [PSE_NUM_W-1:0] number_out;
        logic                 is_prime;
        logic                 out_of_range;
    } verdict_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [PSE_LIMIT_W-1:0] cfg_wdata;

    pse_in_if  cand_if ();
    pse_out_if verdict_if ();

    prime_sieve_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .request   (cand_if),
        .response  (verdict_if)
    );

    candidate_t             pending_candidates[$];
    verdict_t               expected_verdicts[$];
    mark_t                  sieve_marks[PSE_SIZE];
    logic [PSE_LIMIT_W-1:0] sieve_limit;
    logic                   handed_over;
    int                     idle_pct;
    int                     mismatches;
    int                     quiet_cycles;

    always #5 clk = ~clk;

    function automatic verdict_t sieve_candidate(input logic wipe,
                                                 input logic [PSE_NUM_W-1:0] n);
        verdict_t v;
        int       span;
        int       k;
        v.number_out   = n;
        v.is_prime     = 1'b0;
        v.out_of_range = 1'b0;
        span = (int'(sieve_limit) > PSE_SIZE) ? PSE_SIZE : int'(sieve_limit);
        if (wipe)
        begin
            for (k = 0; k < PSE_SIZE; k++)
                sieve_marks[k] = MARK_UNCLEAR;
        end
        else if (int'(n) >= span)
        begin
            v.out_of_range = 1'b1;
        end
        else if (int'(n) >= 2)
        begin
            case (sieve_marks[n])
                MARK_UNCLEAR:
                begin
                    sieve_marks[n] = MARK_PRIME;
                    for (k = 2 * int'(n); k < span; k += int'(n))
                        sieve_marks[k] = MARK_COMPOSITE;
                    v.is_prime = 1'b1;
                end
                MARK_PRIME:
                begin
                    v.is_prime = 1'b1;
                end
                default:
                begin
                    v.is_prime = 1'b0;
                end
            endcase
        end
        return v;
    endfunction

    // Drive inputs on the falling edge.
    always @(negedge clk)
    begin
        if (!rst_n || !cand_if.valid || handed_over)
        begin
            if (rst_n && pending_candidates.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                candidate_t c;
                c = pending_candidates.pop_front();
                cand_if.valid  <= 1'b1;
                cand_if.clear  <= c.clear;
                cand_if.number <= c.number;
            end
            else
            begin
                cand_if.valid  <= 1'b0;
                cand_if.clear  <= 1'($urandom);
                cand_if.number <= 16'($urandom);
            end
        end
        verdict_if.ready <= ($urandom_range(99) >= idle_pct);
    end

    // Sample handshakes on the rising edge; predict and check.
    always @(posedge clk)
    begin : sample
        verdict_t want;
        verdict_t got;
        int       k;
        handed_over <= cand_if.valid && cand_if.ready;
        if (!rst_n)
        begin
            sieve_limit <= PSE_LIMIT_RESET;
            for (k = 0; k < PSE_SIZE; k++)
                sieve_marks[k] = MARK_UNCLEAR;
            quiet_cycles <= 0;
        end
        else
        begin
            if (cfg_we)
                sieve_limit <= cfg_wdata;
            if (cand_if.valid && cand_if.ready)
                expected_verdicts.push_back(sieve_candidate(cand_if.clear, cand_if.number));
            if (verdict_if.valid && verdict_if.ready)
            begin
                got.number_out   = verdict_if.number_out;
                got.is_prime     = verdict_if.is_prime;
                got.out_of_range = verdict_if.out_of_range;
                if (expected_verdicts.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got.number_out !== want.number_out)
                    begin
                        mismatches++;
                        $display("%0t: number_out expected %0d actual %0d",
                                 $time, want.number_out, got.number_out);
                    end
                    if (got.is_prime !== want.is_prime)
                    begin
                        mismatches++;
                        $display("%0t: is_prime for %0d expected %b actual %b",
                                 $time, want.number_out, want.is_prime, got.is_prime);
                    end
                    if (got.out_of_range !== want.out_of_range)
                    begin
                        mismatches++;
                        $display("%0t: out_of_range for %0d expected %b actual %b",
                                 $time, want.number_out, want.out_of_range,
                                 got.out_of_range);
                    end
                end
            end
            if ((cand_if.valid && cand_if.ready) || (verdict_if.valid && verdict_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("prime_sieve_engine regression: fail");
                $finish;
            end
        end
    end

    task automatic offer(input logic wipe, input int n);
        candidate_t c;
        c.clear  = wipe;
        c.number = n[PSE_NUM_W-1:0];
        pending_candidates.push_back(c);
    endtask

    // Hold until every item is taken and answered, then let the block settle.
    task automatic drain();
        while (pending_candidates.size() != 0 || cand_if.valid
               || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic set_limit(input int value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value[PSE_LIMIT_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_phase(input int lim, input int count, input logic wipe);
        int seq;
        int r;
        int n;
        int i;
        set_limit(lim);
        if (wipe)
            offer(1'b1, $urandom_range(65535));
        seq = 2;
        for (i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 70)
            begin
                offer(1'b0, seq);
                seq++;
                if (lim <= 5000 && seq > lim + 3)
                    seq = 2;
            end
            else if (r < 80)
            begin
                offer(1'b0, $urandom_range(65535));
            end
            else if (r < 88)
            begin
                n = lim - 1 + $urandom_range(2);
                offer(1'b0, (n > 65535) ? 65535 : n);
            end
            else if (r < 94)
            begin
                offer(1'b0, $urandom_range(seq + 8));
            end
            else
            begin
                case ($urandom_range(2))
                    0: n = 0;
                    1: n = 1;
                    default: n = 65535;
                endcase
                offer(1'b0, n);
            end
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        cand_if.valid    = 1'b0;
        cand_if.clear    = 1'b0;
        cand_if.number   = '0;
        verdict_if.ready = 1'b0;
        handed_over      = 1'b0;
        idle_pct         = IDLE_PCT;
        mismatches       = 0;
        quiet_cycles     = 0;
        sieve_limit      = PSE_LIMIT_RESET;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        offer(1'b0, 0);
        offer(1'b0, 1);
        offer(1'b0, 2);
        offer(1'b0, 3);
        offer(1'b0, 4);
        offer(1'b0, 65535);
        offer(1'b0, 65534);
        offer(1'b0, 65521);
        offer(1'b0, 2);
        offer(1'b0, 9);
        offer(1'b0, 32768);
        offer(1'b1, 16'hFFFF);

        set_limit(2);
        offer(1'b0, 0);
        offer(1'b0, 1);
        offer(1'b0, 2);
        offer(1'b0, 7);

        set_limit(17'h1FFFF);
        offer(1'b0, 65535);
        offer(1'b0, 40000);
        offer(1'b0, 40000);

        set_limit(3);
        offer(1'b0, 2);
        offer(1'b0, 3);
        offer(1'b0, 4);
        offer(1'b0, 1);

        random_phase(3, 120, 1'b0);
        random_phase(50, 250, 1'b1);
        drain();
        idle_pct = 0;
        random_phase(500, 300, 1'b1);
        drain();
        idle_pct = IDLE_PCT;
        random_phase(4096, 300, 1'b1);
        random_phase(65536, 230, 1'b1);

        drain();
        repeat (20) @(negedge clk);
        if (mismatches == 0)
            $display("prime_sieve_engine regression: pass");
        else
            $display("prime_sieve_engine regression: fail");
        $finish;
    end

endmodule
